FILE: src/lqwv_pkg.sv
package lqwv_pkg;

	localparam int RingDepth = 64;
	localparam int StampW = 32;
	localparam int PingW = 16;
	localparam int FracW = 17;
	localparam logic [FracW-1:0] QOne = 17'h10000;
	localparam int CntSatW = 7;
	localparam int CfgAddrW = 5;

	typedef enum logic [1:0] {
		KIND_OFFER = 2'd0,
		KIND_EVAL  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [CfgAddrW-1:0] {
		REG_PING_LIMIT  = 5'h00,
		REG_JIT_LIMIT   = 5'h04,
		REG_LOSS_LIMIT  = 5'h08,
		REG_CHOKE_LIMIT = 5'h0C,
		REG_WINDOW      = 5'h10,
		REG_INTERVAL    = 5'h14
	} reg_addr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_PRUNE_RD,
		ST_PRUNE_CHK,
		ST_SCAN_RD,
		ST_SCAN_ACC,
		ST_DIV,
		ST_RESULT,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take_item;
		logic do_write;
		logic prune_rd;
		logic prune_drop;
		logic scan_start;
		logic scan_rd;
		logic scan_acc;
		logic div_start;
		logic div_step;
		logic make_result;
		logic do_clear;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip_offer;
		logic ring_empty;
		logic oldest_stale;
		logic scan_last;
		logic div_done;
	} stat_t;

	function automatic logic [FracW-1:0] frac_sat(input logic [FracW-1:0] v);
		frac_sat = (v > QOne) ? QOne : v;
	endfunction

endpackage

FILE: src/link_quality_window_veto.sv
// Link quality window monitor with veto.
// s_axis: one beat per item. tuser = kind (0 offer, 1 evaluate, 2 clear).
//   tdata, low bit up: time_ms[31:0], ping_tenths[47:32], in_loss[64:48],
//   out_loss[81:65], in_choke[98:82], out_choke[115:99], measure_ok[116].
// m_axis: one beat per evaluate item; tdata, low bit up: peak_ping, jitter,
//   peak_in_loss, peak_out_loss, peak_in_choke, peak_out_choke,
//   unavailable_count, vetoed (112 bits).
// APB port writes limits, window and sample interval at 4*index.
// One item at a time: tready is high only in idle. Clear and kind 3 finish
// in idle; an offer that comes before the sample interval is due is dropped,
// else it is written and stale entries are pruned; an evaluate prunes, then
// scans every held entry and runs the one-bit-a-cycle divider.
// Reset empties the ring, disarms the sample timer and loads default
// limits. A stalled result holds m_axis and keeps s_axis_tready low.
module link_quality_window_veto #(
	parameter int RING_DEPTH = lqwv_pkg::RingDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// time_ms, ping_tenths, in_loss, out_loss, in_choke, out_choke, measure_ok
	input  logic [119:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser, // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// peak_ping, jitter, peak_in_loss, peak_out_loss, peak_in_choke,
	// peak_out_choke, unavailable_count, vetoed
	output logic [111:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	lqwv_pkg::cmd_t  cmd;
	lqwv_pkg::stat_t stat;
	logic [15:0] ping_limit_q, jit_limit_q, window_q, interval_q;
	logic [16:0] loss_limit_q, choke_limit_q;
	logic [15:0] r_ping, r_jit;
	logic [16:0] r_il, r_ol, r_ic, r_oc;
	logic [6:0]  r_un;
	logic        r_veto;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_limit_q <= 16'd1500;
			jit_limit_q <= 16'd250;
			loss_limit_q <= 17'd1311;
			choke_limit_q <= 17'd1311;
			window_q <= 16'd5000;
			interval_q <= 16'd100;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				lqwv_pkg::REG_PING_LIMIT:  ping_limit_q <= pwdata[15:0];
				lqwv_pkg::REG_JIT_LIMIT:   jit_limit_q <= pwdata[15:0];
				lqwv_pkg::REG_LOSS_LIMIT:  loss_limit_q <= pwdata[16:0];
				lqwv_pkg::REG_CHOKE_LIMIT: choke_limit_q <= pwdata[16:0];
				lqwv_pkg::REG_WINDOW:      window_q <= pwdata[15:0];
				lqwv_pkg::REG_INTERVAL:    interval_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			lqwv_pkg::REG_PING_LIMIT:  prdata = {16'd0, ping_limit_q};
			lqwv_pkg::REG_JIT_LIMIT:   prdata = {16'd0, jit_limit_q};
			lqwv_pkg::REG_LOSS_LIMIT:  prdata = {15'd0, loss_limit_q};
			lqwv_pkg::REG_CHOKE_LIMIT: prdata = {15'd0, choke_limit_q};
			lqwv_pkg::REG_WINDOW:      prdata = {16'd0, window_q};
			lqwv_pkg::REG_INTERVAL:    prdata = {16'd0, interval_q};
			default:                   prdata = '0;
		endcase
	end

	lqwv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_kind(s_axis_tuser),
		.out_ready(m_axis_tready), .stat(stat), .cmd(cmd),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
	);

	lqwv_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_kind(s_axis_tuser), .in_time(s_axis_tdata[31:0]),
		.in_ping(s_axis_tdata[47:32]), .in_il(s_axis_tdata[64:48]),
		.in_ol(s_axis_tdata[81:65]), .in_ic(s_axis_tdata[98:82]),
		.in_oc(s_axis_tdata[115:99]), .in_ok(s_axis_tdata[116]),
		.ping_limit(ping_limit_q), .jitter_limit(jit_limit_q),
		.loss_limit(loss_limit_q), .choke_limit(choke_limit_q),
		.window_ms(window_q), .sample_interval_ms(interval_q),
		.res_ping(r_ping), .res_jitter(r_jit), .res_il(r_il), .res_ol(r_ol),
		.res_ic(r_ic), .res_oc(r_oc), .res_unavail(r_un), .res_veto(r_veto)
	);

	assign m_axis_tdata = {4'd0, r_veto, r_un, r_oc, r_ic, r_ol, r_il, r_jit, r_ping};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_veto_unavail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[106:100] != 7'd0 |-> m_axis_tdata[107])
		else $error("veto missing");

endmodule

FILE: src/lqwv_ram.sv
module lqwv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/lqwv_ctrl.sv
module lqwv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_kind,
	input  logic               out_ready,
	input  lqwv_pkg::stat_t    stat,
	output lqwv_pkg::cmd_t     cmd,
	output logic               in_ready,
	output logic               out_valid
);

	lqwv_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lqwv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			lqwv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					case (in_kind)
						lqwv_pkg::KIND_OFFER: state_d = lqwv_pkg::ST_WRITE;
						lqwv_pkg::KIND_EVAL:  state_d = lqwv_pkg::ST_PRUNE_RD;
						lqwv_pkg::KIND_CLEAR: cmd.do_clear = 1'b1;
						default: ;
					endcase
				end
			end
			lqwv_pkg::ST_WRITE: begin
				if (stat.skip_offer) begin
					state_d = lqwv_pkg::ST_IDLE;
				end else begin
					cmd.do_write = 1'b1;
					state_d = lqwv_pkg::ST_PRUNE_RD;
				end
			end
			lqwv_pkg::ST_PRUNE_RD: begin
				if (stat.ring_empty) begin
					cmd.scan_start = 1'b1;
					state_d = lqwv_pkg::ST_SCAN_RD;
				end else begin
					cmd.prune_rd = 1'b1;
					state_d = lqwv_pkg::ST_PRUNE_CHK;
				end
			end
			lqwv_pkg::ST_PRUNE_CHK: begin
				if (stat.oldest_stale) begin
					cmd.prune_drop = 1'b1;
					state_d = lqwv_pkg::ST_PRUNE_RD;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = lqwv_pkg::ST_SCAN_RD;
				end
			end
			lqwv_pkg::ST_SCAN_RD: begin
				if (stat.skip_offer) begin
					state_d = lqwv_pkg::ST_IDLE;
				end else if (stat.scan_last) begin
					cmd.div_start = 1'b1;
					state_d = lqwv_pkg::ST_DIV;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d = lqwv_pkg::ST_SCAN_ACC;
				end
			end
			lqwv_pkg::ST_SCAN_ACC: begin
				cmd.scan_acc = 1'b1;
				state_d = lqwv_pkg::ST_SCAN_RD;
			end
			lqwv_pkg::ST_DIV: begin
				if (stat.div_done) begin
					state_d = lqwv_pkg::ST_RESULT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			lqwv_pkg::ST_RESULT: begin
				cmd.make_result = 1'b1;
				state_d = lqwv_pkg::ST_OUT;
			end
			lqwv_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = lqwv_pkg::ST_IDLE;
				end
			end
			default: state_d = lqwv_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: src/lqwv_dp.sv
module lqwv_dp #(
	parameter int RING_DEPTH = lqwv_pkg::RingDepth
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lqwv_pkg::cmd_t                 cmd,
	output lqwv_pkg::stat_t                stat,
	input  logic [1:0]                     in_kind,
	input  logic [lqwv_pkg::StampW-1:0]    in_time,
	input  logic [lqwv_pkg::PingW-1:0]     in_ping,
	input  logic [lqwv_pkg::FracW-1:0]     in_il,
	input  logic [lqwv_pkg::FracW-1:0]     in_ol,
	input  logic [lqwv_pkg::FracW-1:0]     in_ic,
	input  logic [lqwv_pkg::FracW-1:0]     in_oc,
	input  logic                           in_ok,
	input  logic [15:0]                    ping_limit,
	input  logic [15:0]                    jitter_limit,
	input  logic [lqwv_pkg::FracW-1:0]     loss_limit,
	input  logic [lqwv_pkg::FracW-1:0]     choke_limit,
	input  logic [15:0]                    window_ms,
	input  logic [15:0]                    sample_interval_ms,
	output logic [lqwv_pkg::PingW-1:0]     res_ping,
	output logic [15:0]                    res_jitter,
	output logic [lqwv_pkg::FracW-1:0]     res_il,
	output logic [lqwv_pkg::FracW-1:0]     res_ol,
	output logic [lqwv_pkg::FracW-1:0]     res_ic,
	output logic [lqwv_pkg::FracW-1:0]     res_oc,
	output logic [lqwv_pkg::CntSatW-1:0]   res_unavail,
	output logic                           res_veto
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int SUMW = lqwv_pkg::PingW + CW;
	localparam int DCW = $clog2(SUMW + 1);
	localparam int RW = lqwv_pkg::StampW + lqwv_pkg::PingW + 4 * lqwv_pkg::FracW + 1;
	localparam logic [CW-1:0] Full = CW'(RING_DEPTH);

	logic [lqwv_pkg::StampW-1:0] time_q, due_q;
	logic                        armed_q, eval_q;
	logic                        scan_q;
	logic [lqwv_pkg::PingW-1:0]  ping_q;
	logic [lqwv_pkg::FracW-1:0]  il_q, ol_q, ic_q, oc_q;
	logic                        ok_q;
	logic [AW-1:0]               oldest_q, idx_q;
	logic [CW-1:0]               count_q, left_q, invalid_q, valid_q;
	logic [lqwv_pkg::PingW-1:0]  pk_ping_q, prev_q;
	logic [lqwv_pkg::FracW-1:0]  pk_il_q, pk_ol_q, pk_ic_q, pk_oc_q;
	logic [SUMW-1:0]             total_q, rem_q, quo_q;
	logic [DCW-1:0]              div_cnt_q;

	logic [RW-1:0]   wdata, rdata;
	logic [AW-1:0]   waddr, raddr;
	logic [lqwv_pkg::StampW-1:0] r_stamp, cutoff, due_diff, stale_diff;
	logic [lqwv_pkg::PingW-1:0]  r_ping, pdiff;
	logic [lqwv_pkg::FracW-1:0]  r_il, r_ol, r_ic, r_oc;
	logic                        r_ok;
	logic [AW-1:0]               wr_oldest;
	logic [CW-1:0]               wr_count, diffs;
	logic [SUMW:0]               rem_try;
	logic [CW-1:0]               inv_fix;
	logic [SUMW-1:0]             jit_w;
	logic [15:0]                 jit_sat;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(RING_DEPTH)) begin
			s = s - (CW+1)'(RING_DEPTH);
		end
		wrap_add = s[AW-1:0];
	endfunction

	assign {r_stamp, r_ping, r_il, r_ol, r_ic, r_oc, r_ok} = rdata;
	assign due_diff = time_q - due_q;
	assign cutoff = time_q - {16'd0, window_ms};
	assign stale_diff = r_stamp - cutoff;
	assign wr_oldest = (count_q == Full) ? wrap_add(oldest_q, CW'(1)) : oldest_q;
	assign wr_count = (count_q == Full) ? count_q - CW'(1) : count_q;
	assign waddr = wrap_add(wr_oldest, wr_count);
	assign wdata = {time_q, ping_q, il_q, ol_q, ic_q, oc_q, ok_q};
	assign raddr = cmd.prune_rd ? oldest_q : idx_q;
	assign pdiff = (r_ping > prev_q) ? r_ping - prev_q : prev_q - r_ping;
	assign diffs = (valid_q == '0) ? '0 : valid_q - CW'(1);
	assign rem_try = {rem_q, quo_q[SUMW-1]} - (SUMW+1)'(diffs);

	lqwv_ram #(.WIDTH(RW), .DEPTH(RING_DEPTH)) u_ring (
		.clk(clk), .we(cmd.do_write), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic skip_w;
	assign skip_w = armed_q & due_diff[31];

	always_comb begin
		stat.skip_offer = 1'b0;
		if (!eval_q && !scan_q) begin
			stat.skip_offer = skip_w;
		end else if (!eval_q && scan_q) begin
			stat.skip_offer = 1'b1;
		end
		stat.ring_empty = (count_q == '0);
		stat.oldest_stale = stale_diff[31];
		stat.scan_last = (left_q == '0);
		stat.div_done = (div_cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q <= '0;
			due_q <= '0;
			armed_q <= 1'b0;
			eval_q <= 1'b0;
			scan_q <= 1'b0;
			left_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.take_item) begin
				eval_q <= (in_kind == lqwv_pkg::KIND_EVAL);
				scan_q <= 1'b0;
			end
			if (cmd.do_clear) begin
				oldest_q <= '0;
				count_q <= '0;
				due_q <= '0;
				armed_q <= 1'b0;
			end
			if (cmd.do_write) begin
				oldest_q <= wr_oldest;
				count_q <= wr_count + CW'(1);
				due_q <= time_q + {16'd0, sample_interval_ms};
				armed_q <= 1'b1;
			end
			if (cmd.prune_drop) begin
				oldest_q <= wrap_add(oldest_q, CW'(1));
				count_q <= count_q - CW'(1);
			end
			if (cmd.scan_start) begin
				scan_q <= 1'b1;
				left_q <= count_q;
			end
			if (cmd.scan_rd) begin
				left_q <= left_q - CW'(1);
			end
			if (cmd.div_start) begin
				div_cnt_q <= (diffs == '0) ? '0 : DCW'(SUMW);
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			time_q <= in_time;
			ping_q <= in_ping;
			il_q <= lqwv_pkg::frac_sat(in_il);
			ol_q <= lqwv_pkg::frac_sat(in_ol);
			ic_q <= lqwv_pkg::frac_sat(in_ic);
			oc_q <= lqwv_pkg::frac_sat(in_oc);
			ok_q <= in_ok;
		end
		if (cmd.scan_start) begin
			idx_q <= oldest_q;
			pk_ping_q <= '0;
			pk_il_q <= '0;
			pk_ol_q <= '0;
			pk_ic_q <= '0;
			pk_oc_q <= '0;
			prev_q <= '0;
			invalid_q <= '0;
			valid_q <= '0;
			total_q <= '0;
		end
		if (cmd.scan_rd) begin
			idx_q <= wrap_add(idx_q, CW'(1));
		end
		if (cmd.scan_acc) begin
			if (!r_ok) begin
				invalid_q <= invalid_q + CW'(1);
			end else begin
				if (r_ping > pk_ping_q) pk_ping_q <= r_ping;
				if (r_il > pk_il_q) pk_il_q <= r_il;
				if (r_ol > pk_ol_q) pk_ol_q <= r_ol;
				if (r_ic > pk_ic_q) pk_ic_q <= r_ic;
				if (r_oc > pk_oc_q) pk_oc_q <= r_oc;
				if (valid_q != '0) total_q <= total_q + SUMW'(pdiff);
				prev_q <= r_ping;
				valid_q <= valid_q + CW'(1);
			end
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= total_q;
		end
		if (cmd.div_step) begin
			if (!rem_try[SUMW]) begin
				rem_q <= rem_try[SUMW-1:0];
				quo_q <= {quo_q[SUMW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SUMW-2:0], quo_q[SUMW-1]};
				quo_q <= {quo_q[SUMW-2:0], 1'b0};
			end
		end
		if (cmd.make_result) begin
			res_ping <= pk_ping_q;
			res_jitter <= jit_sat;
			res_il <= pk_il_q;
			res_ol <= pk_ol_q;
			res_ic <= pk_ic_q;
			res_oc <= pk_oc_q;
			res_unavail <= (inv_fix > CW'(127)) ? 7'd127 : lqwv_pkg::CntSatW'(inv_fix);
			res_veto <= (pk_ping_q >= ping_limit) || (jit_sat >= jitter_limit) ||
				(pk_il_q >= loss_limit) || (pk_ol_q >= loss_limit) ||
				(pk_ic_q >= choke_limit) || (pk_oc_q >= choke_limit) ||
				(inv_fix != '0);
		end
	end

	assign inv_fix = (valid_q < CW'(2) && invalid_q == '0) ? CW'(1) : invalid_q;
	assign jit_w = (diffs == '0) ? '0 : quo_q;
	assign jit_sat = (jit_w > SUMW'(16'hFFFF)) ? 16'hFFFF : jit_w[15:0];

endmodule
